>>> src/squared_exponential_kernel_unit_macros.svh
// ============================================================================
// Squared exponential kernel unit: assertion macros
// Concurrent check wrappers clocked on clk and disabled while rst_n is low.
// Defining NO_ASSERTIONS turns every check into nothing.
// ============================================================================
`ifndef SQUARED_EXPONENTIAL_KERNEL_UNIT_MACROS_SVH
`define SQUARED_EXPONENTIAL_KERNEL_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SEK_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sek: same-cycle check failed");
// next-cycle implication
`define SEK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sek: next-cycle check failed");
`else
`define SEK_ASSERT_IMPLY(label, ante, cons)
`define SEK_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/sek_pkg.sv
// ============================================================================
// Squared exponential kernel package
// Shared widths, register indexes, exp table and pipeline stage type.
// ============================================================================
package sek_pkg;

    localparam int COORD_W     = 16;
    localparam int COORD_NUM   = 4;
    localparam int OUT_W       = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int DIMS_W      = 3;
    localparam int ARG_BITS    = 20;
    localparam int ACC_W       = 32;

    localparam logic [DIMS_W-1:0]     DIMS_RESET     = 3'd4;
    localparam logic [CFG_DATA_W-1:0] VARIANCE_RESET = 24'd65536;
    localparam logic [CFG_DATA_W-1:0] INV_SCALE_RESET = 24'd32768;
    localparam logic [63:0]           ROUND_HALF     = 64'h0000_0000_8000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DIMS      = 2'd0,
        REG_VARIANCE  = 2'd1,
        REG_INV_SCALE = 2'd2
    } cfg_reg_t;

    // round(exp(-2^(b-16)) * 2^32), b = 0..19
    localparam logic [ACC_W-1:0] EXP_TABLE [0:ARG_BITS-1] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
    };

    // one stage of the exp range reduction
    typedef struct packed {
        logic [ARG_BITS-1:0] arg;
        logic                big;   // argument reached 16.0
        logic                one;   // accumulator still exactly 1.0
        logic [ACC_W-1:0]    acc;   // Q.32 when one is clear
    } exp_stage_t;

endpackage

>>> src/sek_intf.sv
// ============================================================================
// Squared exponential kernel channel interfaces
// Point-pair input channel and kernel value output channel, valid/ready.
// ============================================================================
interface sek_pair_if;
    logic                                valid;
    logic                                ready;
    logic signed [sek_pkg::COORD_W-1:0]  point_a_0;
    logic signed [sek_pkg::COORD_W-1:0]  point_a_1;
    logic signed [sek_pkg::COORD_W-1:0]  point_a_2;
    logic signed [sek_pkg::COORD_W-1:0]  point_a_3;
    logic signed [sek_pkg::COORD_W-1:0]  point_b_0;
    logic signed [sek_pkg::COORD_W-1:0]  point_b_1;
    logic signed [sek_pkg::COORD_W-1:0]  point_b_2;
    logic signed [sek_pkg::COORD_W-1:0]  point_b_3;

    modport source (
        output valid, point_a_0, point_a_1, point_a_2, point_a_3,
        output point_b_0, point_b_1, point_b_2, point_b_3,
        input  ready
    );
    modport sink (
        input  valid, point_a_0, point_a_1, point_a_2, point_a_3,
        input  point_b_0, point_b_1, point_b_2, point_b_3,
        output ready
    );
endinterface

interface sek_kernel_if;
    logic                         valid;
    logic                         ready;
    logic [sek_pkg::OUT_W-1:0]    kernel_value;

    modport source (output valid, kernel_value, input ready);
    modport sink (input valid, kernel_value, output ready);
endinterface

>>> src/squared_exponential_kernel_unit.sv
// ============================================================================
// Squared exponential kernel unit
// k = signal_variance * exp(-inverse_scale * |a - b|^2), one pair per cycle when the output is not stalled.
// ============================================================================
// Takes one point pair per clock while the output is not stalled and returns
// one unsigned Q8.16 kernel value per pair, in order. Throughput is one
// transaction per cycle when nothing stalls. The exp evaluation spends one
// pipeline stage (one 32x32 multiplier) on each of the 20 argument bits,
// after four stages for difference, square, sum and scaling, and one for
// the variance multiply that feeds the output register.
// Every stage has its own valid bit and moves whenever the stage after it is
// empty or moving, so bubbles are squeezed out while the output is stalled.
// Arguments of 16.0 or more give 0. Configuration (dims_in_use,
// signal_variance, inverse_scale at indexes 0, 1, 2) is written through
// cfg_we/cfg_index/cfg_data while no transaction is in flight; writes to an
// unknown index are dropped.
// ============================================================================
`include "squared_exponential_kernel_unit_macros.svh"

module squared_exponential_kernel_unit #(
    parameter int MAX_DIMS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    sek_pair_if.sink                            pair,
    sek_kernel_if.source                        kernel,
    input  logic                                cfg_we,
    input  logic [sek_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sek_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sek_pkg::*;

    // stage map
    localparam int ST_DIFF    = 0;
    localparam int ST_SQ      = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_ARG     = 3;
    localparam int ST_EXP0    = 4;
    localparam int ST_OUT     = ST_EXP0 + ARG_BITS;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam int DIM_LIMIT  = (MAX_DIMS < COORD_NUM) ? MAX_DIMS : COORD_NUM;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int SCALED_W   = SUM_W + CFG_DATA_W;
    localparam int FRAC_SHIFT = 24;
    localparam int OUT_PROD_W = OUT_W + ACC_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIMS_W-1:0]     dims_reg;
    logic [CFG_DATA_W-1:0] variance_reg;
    logic [CFG_DATA_W-1:0] inv_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg      <= DIMS_RESET;
            variance_reg  <= VARIANCE_RESET;
            inv_scale_reg <= INV_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DIMS:      dims_reg      <= cfg_data[DIMS_W-1:0];
                REG_VARIANCE:  variance_reg  <= cfg_data;
                REG_INV_SCALE: inv_scale_reg <= cfg_data;
                default:       ;   // unknown index: dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage moves when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;

    assign adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || kernel.ready;

    genvar s;
    generate
        for (s = 0; s < NUM_STAGES - 1; s++)
        begin : g_adv
            assign adv[s] = !valid_reg[s] || adv[s+1];
        end
    endgenerate

    assign pair.ready = adv[ST_DIFF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[ST_DIFF])
            begin
                valid_reg[ST_DIFF] <= pair.valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: absolute coordinate differences, unused dims forced to 0
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] coord_a [COORD_NUM];
    logic signed [COORD_W-1:0] coord_b [COORD_NUM];
    logic [COORD_W-1:0]        absdiff_next [COORD_NUM];
    logic [COORD_W-1:0]        absdiff_reg  [COORD_NUM];

    assign coord_a[0] = pair.point_a_0;
    assign coord_a[1] = pair.point_a_1;
    assign coord_a[2] = pair.point_a_2;
    assign coord_a[3] = pair.point_a_3;
    assign coord_b[0] = pair.point_b_0;
    assign coord_b[1] = pair.point_b_1;
    assign coord_b[2] = pair.point_b_2;
    assign coord_b[3] = pair.point_b_3;

    always_comb
    begin
        for (int i = 0; i < COORD_NUM; i++)
        begin
            logic signed [COORD_W:0] d;
            logic signed [COORD_W:0] mag;
            d   = {coord_a[i][COORD_W-1], coord_a[i]} - {coord_b[i][COORD_W-1], coord_b[i]};
            mag = d[COORD_W] ? -d : d;
            if ((i < DIM_LIMIT) && (dims_reg > DIMS_W'(i)))
                absdiff_next[i] = mag[COORD_W-1:0];
            else
                absdiff_next[i] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1..3: squares, exact sum, scaling by inverse_scale
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]     sq_reg [COORD_NUM];
    logic [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SCALED_W-1:0] scaled;
    logic [ARG_BITS-1:0] arg_reg;
    logic                big_reg;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < COORD_NUM; i++)
        begin
            sum_next = sum_next + SUM_W'(sq_reg[i]);
        end
    end

    assign scaled = SCALED_W'(sum_reg) * SCALED_W'(inv_scale_reg);

    always_ff @(posedge clk)
    begin
        if (adv[ST_DIFF])
        begin
            absdiff_reg <= absdiff_next;
        end
        if (adv[ST_SQ])
        begin
            for (int i = 0; i < COORD_NUM; i++)
            begin
                sq_reg[i] <= SQ_W'(absdiff_reg[i]) * SQ_W'(absdiff_reg[i]);
            end
        end
        if (adv[ST_SUM])
        begin
            sum_reg <= sum_next;
        end
        if (adv[ST_ARG])
        begin
            // Q.16 argument; anything at or above 16.0 flags a zero result
            arg_reg <= scaled[FRAC_SHIFT +: ARG_BITS];
            big_reg <= |scaled[SCALED_W-1:FRAC_SHIFT+ARG_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stages 4..23: exp(-arg) by range reduction, argument bit 19 first
    // ------------------------------------------------------------------
    exp_stage_t ex_in  [ARG_BITS+1];
    exp_stage_t exp_reg [ARG_BITS];

    assign ex_in[0] = '{arg: arg_reg, big: big_reg, one: 1'b1, acc: '0};

    genvar k;
    generate
        for (k = 0; k < ARG_BITS; k++)
        begin : g_exp
            localparam int BIT = ARG_BITS - 1 - k;
            logic [2*ACC_W-1:0] prod;
            logic [2*ACC_W-1:0] prod_rnd;
            exp_stage_t         exp_next;

            assign prod     = (2*ACC_W)'(ex_in[k].acc) * (2*ACC_W)'(EXP_TABLE[BIT]);
            assign prod_rnd = prod + ROUND_HALF;

            always_comb
            begin
                exp_next = ex_in[k];
                if (ex_in[k].arg[BIT])
                begin
                    // first factor of 1.0 is exact: load the table entry
                    exp_next.one = 1'b0;
                    exp_next.acc = ex_in[k].one ? EXP_TABLE[BIT] : prod_rnd[2*ACC_W-1:ACC_W];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[ST_EXP0+k])
                begin
                    exp_reg[k] <= exp_next;
                end
            end

            assign ex_in[k+1] = exp_reg[k];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 24: variance scaling into the output register
    // ------------------------------------------------------------------
    exp_stage_t            fin;
    logic [OUT_PROD_W-1:0] out_prod;
    logic [OUT_PROD_W-1:0] out_rnd;
    logic [OUT_W-1:0]      kernel_next;
    logic [OUT_W-1:0]      kernel_reg;

    assign fin      = ex_in[ARG_BITS];
    assign out_prod = OUT_PROD_W'(variance_reg) * OUT_PROD_W'(fin.acc);
    assign out_rnd  = out_prod + OUT_PROD_W'(ROUND_HALF);

    // result never exceeds signal_variance, so it always fits in 24 bits
    always_comb
    begin
        if (fin.big)
            kernel_next = '0;
        else if (fin.one)
            kernel_next = variance_reg;
        else
            kernel_next = out_rnd[OUT_PROD_W-1:ACC_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            kernel_reg <= kernel_next;
        end
    end

    assign kernel.valid        = valid_reg[ST_OUT];
    assign kernel.kernel_value = kernel_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SEK_ASSERT_NEXT(a_accept_fills_first, pair.valid && pair.ready, valid_reg[ST_DIFF])
    `SEK_ASSERT_IMPLY(a_out_below_variance, kernel.valid, kernel.kernel_value <= variance_reg)
    `SEK_ASSERT_NEXT(a_big_arg_gives_zero, valid_reg[ST_OUT-1] && fin.big && adv[ST_OUT], kernel.kernel_value == '0)
    `SEK_ASSERT_IMPLY(a_stall_holds_pipe, kernel.valid && !kernel.ready, !adv[ST_OUT])

endmodule
